>>> hdl/aes128_pkg.sv
package aes128_pkg;

  localparam int unsigned BLOCK_W = 128;
  localparam int unsigned HALF_W  = 64;
  localparam int unsigned ROUNDS  = 10;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  typedef logic [BLOCK_W-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // byte i of the block sits at bits 127-8i..120-8i
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    return b[BLOCK_W-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    return o;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t o;
    logic [7:0] a, b, d, e, t;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a = get_byte(s, 4*c);
      b = get_byte(s, 4*c+1);
      d = get_byte(s, 4*c+2);
      e = get_byte(s, 4*c+3);
      t = a ^ b ^ d ^ e;
      o[BLOCK_W-1-8*(4*c)   -: 8] = a ^ t ^ xtime(a ^ b);
      o[BLOCK_W-1-8*(4*c+1) -: 8] = b ^ t ^ xtime(b ^ d);
      o[BLOCK_W-1-8*(4*c+2) -: 8] = d ^ t ^ xtime(d ^ e);
      o[BLOCK_W-1-8*(4*c+3) -: 8] = e ^ t ^ xtime(e ^ a);
    end
    return o;
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

>>> hdl/aes128_block_encrypt.sv
// AES-128 encryption, fully unrolled: one 128-bit block accepted per cycle and
// one ciphertext word out per cycle while out_tready does not stall; one register
// stage for the initial key add, then one per round. The round keys are expanded from
// cfg key registers in a pipeline that travels with each block, so a key written
// while idle applies to the next block. Stalls on out_tready freeze the whole
// pipeline; nothing is dropped or repeated.
module aes128_block_encrypt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [aes128_pkg::BLOCK_W-1:0]     in_tdata,   // plain_low, plain_high
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [aes128_pkg::BLOCK_W-1:0]     out_tdata,  // cipher_low, cipher_high
  input  logic                               cfg_we,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [aes128_pkg::HALF_W-1:0]      cfg_wdata
);
  import aes128_pkg::*;

  localparam int unsigned STAGES = ROUNDS + 1;

  logic [HALF_W-1:0] key_hi_r, key_lo_r;
  logic              vld_r   [STAGES];
  block_t            st_r    [STAGES];
  block_t            rk_r    [STAGES-1];
  block_t            st_nxt  [STAGES];
  block_t            rk_nxt  [STAGES];
  logic              adv;
  block_t            key0, plain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_KEY_HIGH: key_hi_r <= cfg_wdata;
        REG_KEY_LOW:  key_lo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance everything when the output stage is empty or being taken
  assign adv       = !vld_r[STAGES-1] || out_tready;
  assign in_tready = adv;
  assign key0      = {key_hi_r, key_lo_r};
  assign plain     = {in_tdata[HALF_W-1:0], in_tdata[BLOCK_W-1:HALF_W]};

  always_comb begin
    st_nxt[0] = plain ^ key0;
    rk_nxt[0] = key0;
    for (int s = 1; s < STAGES; s++) begin
      rk_nxt[s] = next_key(rk_r[s-1], RCON[s-1]);
      if (s == STAGES-1) begin
        st_nxt[s] = sub_shift(st_r[s-1]) ^ rk_nxt[s];
      end else begin
        st_nxt[s] = mix(sub_shift(st_r[s-1])) ^ rk_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < STAGES; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s < STAGES; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
      for (int s = 0; s < STAGES-1; s++) begin
        rk_r[s] <= rk_nxt[s];
      end
    end
  end

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {st_r[STAGES-1][HALF_W-1:0], st_r[STAGES-1][BLOCK_W-1:HALF_W]};

endmodule

>>> tb/aes128_block_encrypt_tb.sv
module aes128_block_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes128_pkg::*;

  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct {
    logic [127:0] key;
    logic [127:0] plain;
    bit           typed;
    logic [127:0] cipher;
  } vector_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [BLOCK_W-1:0]   in_tdata;    // plain_low, plain_high
  logic                 out_tvalid;
  logic                 out_tready;
  logic [BLOCK_W-1:0]   out_tdata;   // cipher_low, cipher_high
  logic                 cfg_we;
  cfg_reg_t             cfg_idx;
  logic [HALF_W-1:0]    cfg_wdata;

  logic [63:0]  key_hi_q;
  logic [63:0]  key_lo_q;
  logic [127:0] cipher_q[$];
  bit           typed_pending;
  logic [127:0] typed_cipher;
  int unsigned  errors;
  vector_t      vectors[$];

  aes128_block_encrypt i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block is bits 127-8i..120-8i
  function automatic logic [127:0] cipher_model(input logic [127:0] key,
                                                input logic [127:0] plain);
    logic [7:0]   rk[176];
    logic [7:0]   st[16];
    logic [7:0]   sh[16];
    logic [7:0]   w[4];
    logic [7:0]   rc;
    logic [7:0]   u, a, b, d, e, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = plain[127-8*i -: 8] ^ rk[i];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        u = w[0];
        w[0] = SBOX[w[1]] ^ rc;
        w[1] = SBOX[w[2]];
        w[2] = SBOX[w[3]];
        w[3] = SBOX[u];
        rc = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i+j-16] ^ w[j];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) sh[k+4*c] = SBOX[st[k + 4*((c+k) % 4)]];
      end
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a = sh[4*c]; b = sh[4*c+1]; d = sh[4*c+2]; e = sh[4*c+3];
          all = a ^ b ^ d ^ e;
          sh[4*c]   = a ^ all ^ gf_double(a ^ b);
          sh[4*c+1] = b ^ all ^ gf_double(b ^ d);
          sh[4*c+2] = d ^ all ^ gf_double(d ^ e);
          sh[4*c+3] = e ^ all ^ gf_double(e ^ a);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // track key writes and accepted blocks; predict on acceptance
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      if (cfg_idx == REG_KEY_HIGH) key_hi_q <= cfg_wdata;
      else key_lo_q <= cfg_wdata;
    end
    if (rst_n && in_tvalid && in_tready) begin
      if (typed_pending) cipher_q.push_back(typed_cipher);
      else cipher_q.push_back(cipher_model({key_hi_q, key_lo_q},
                                           {in_tdata[63:0], in_tdata[127:64]}));
    end
  end

  always @(posedge clk) begin
    logic [127:0] exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_tdata);
        errors++;
      end else begin
        exp_c = cipher_q.pop_front();
        if (out_tdata[63:0] !== exp_c[127:64]) begin
          $display("%0t: cipher_high expected %h actual %h", $time, exp_c[127:64],
                   out_tdata[63:0]);
          errors++;
        end
        if (out_tdata[127:64] !== exp_c[63:0]) begin
          $display("%0t: cipher_low expected %h actual %h", $time, exp_c[63:0],
                   out_tdata[127:64]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, a few full-speed stretches, one long hold-off
  initial begin
    int unsigned cyc;
    int unsigned mode;
    bit          held;
    out_tready = 1'b0;
    cyc = 0;
    held = 0;
    forever begin
      @(posedge clk);
      cyc++;
      // hold off while the sender is busy so the pipeline fills
      if (!held && cyc >= 300 && in_tvalid) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        cyc += 400;
      end
      mode = (cyc / 500) % 4;
      if (mode == 0) out_tready <= 1'b1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else if (mode == 2) out_tready <= ($urandom_range(0, 1) != 0);
      else out_tready <= ((cyc % 7) < 4);
    end
  end

  task automatic wait_idle();
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [127:0] key);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_KEY_HIGH;
    cfg_wdata <= key[127:64];
    @(posedge clk);
    cfg_idx   <= REG_KEY_LOW;
    cfg_wdata <= key[63:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // offer one word and hold it until taken; valid stays high afterwards
  task automatic send_block(input logic [127:0] plain);
    bit taken;
    in_tvalid <= 1'b1;
    in_tdata  <= {plain[63:0], plain[127:64]};
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
  endtask

  function automatic logic [127:0] rand_block();
    logic [127:0] v;
    int unsigned  pick;
    v = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick == 0) v = '0;
    else if (pick == 1) v = '1;
    else if (pick == 2) v = 128'h1 << $urandom_range(0, 127);
    else if (pick == 3) v = ~(128'h1 << $urandom_range(0, 127));
    return v;
  endfunction

  initial begin
    logic [127:0] cur_key;
    logic [127:0] key;
    int unsigned  burst;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_idx    = REG_KEY_HIGH;
    cfg_wdata  = '0;
    key_hi_q   = '0;
    key_lo_q   = '0;
    errors     = 0;
    typed_pending = 0;
    typed_cipher  = '0;

    vectors = '{
      '{128'h0, 128'h0, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
      '{128'h0, '1, 0, 128'h0},
      '{128'h000102030405060708090a0b0c0d0e0f, 128'h00112233445566778899aabbccddeeff,
        1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
      '{128'h000102030405060708090a0b0c0d0e0f, 128'h0, 0, 128'h0},
      '{128'h000102030405060708090a0b0c0d0e0f, '1, 0, 128'h0},
      '{'1, 128'h0, 0, 128'h0},
      '{'1, '1, 0, 128'h0},
      '{'1, {8{16'haa55}}, 0, 128'h0},
      '{{8{16'h55aa}}, {8{16'h55aa}}, 0, 128'h0},
      '{{8{16'h55aa}}, 128'h1, 0, 128'h0},
      '{{64'h0, 64'hffffffffffffffff}, {64'hffffffffffffffff, 64'h0}, 0, 128'h0},
      '{{64'hffffffffffffffff, 64'h0}, {64'h0, 64'hffffffffffffffff}, 0, 128'h0},
      '{128'h80000000000000000000000000000001, 128'h80000000000000000000000000000001,
        0, 128'h0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // the first row runs on the reset key
    cur_key = '0;
    foreach (vectors[n]) begin
      if (vectors[n].key !== cur_key) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        load_key(vectors[n].key);
        cur_key = vectors[n].key;
      end
      typed_pending <= vectors[n].typed;
      typed_cipher  <= vectors[n].cipher;
      send_block(vectors[n].plain);
    end
    in_tvalid <= 1'b0;
    typed_pending <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) key = '0;
      else if (p == 1) key = '1;
      else key = rand_block();
      load_key(key);
      for (int n = 0; n < PHASE_ITEMS; n += burst) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst; k++) send_block(rand_block());
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      in_tvalid <= 1'b0;
      @(posedge clk);
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
